@@ sv/voxel_to_image_box_macros.svh @@
// ----------------------------------------------------------------------------
// voxel_to_image_box_macros
// Assertion macros shared by the voxel_to_image_box checkers.
// ----------------------------------------------------------------------------
`ifndef VOXEL_TO_IMAGE_BOX_MACROS_SVH
`define VOXEL_TO_IMAGE_BOX_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define VTIB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define VTIB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/vtib_pkg.sv @@
// ----------------------------------------------------------------------------
// vtib_pkg
// Widths, register codes, item types and arithmetic helpers for the
// voxel to image box block.
// ----------------------------------------------------------------------------
package vtib_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int INDEX_BITS  = 24;

    localparam int VOXEL_W     = 24;
    localparam int BELIEF_W    = 16;
    localparam int GRID_W      = 13;
    localparam int PI_W        = 11;
    localparam int SCALE_W     = 24;
    localparam int OFFSET_W    = 32;
    localparam int PIX_W       = 16;
    localparam int BLUE_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int IDX_USE     = (INDEX_BITS < VOXEL_W) ? INDEX_BITS : VOXEL_W;
    localparam int DIV_STEP    = 4;
    localparam int DIV_STAGES  = (INDEX_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int DIVW        = DIV_STAGES * DIV_STEP;
    localparam int SIZE_W      = 2 * GRID_W;
    localparam int SPLIT_DEPTH = 2 * DIV_STAGES + 1;

    localparam int U_RAW_W     = DIVW + PI_W + 1;
    localparam int U_W         = 32;
    localparam int PROD_W      = U_W + SCALE_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int Q_W         = SUM_W - FRAC_BITS;
    localparam int MAP_DEPTH   = 5;
    localparam int NUM_LANES   = 4;

    localparam int BLUE_PW     = BELIEF_W + BLUE_W + 1;
    localparam int BLUE_GAIN   = 255;
    localparam int BLUE_ROUND  = 1 << (BELIEF_W - 1);
    localparam int PIX_MAX     = (1 << (PIX_W - 1)) - 1;
    localparam int PIX_MIN     = -(1 << (PIX_W - 1));

    localparam logic [U_W-1:0]     U_MAX     = '1;
    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << FRAC_BITS);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_COLUMNS   = 3'd0,
        REG_GRID_ROWS      = 3'd1,
        REG_PIXEL_INTERVAL = 3'd2,
        REG_SCALE_X        = 3'd3,
        REG_SCALE_Y        = 3'd4,
        REG_OFFSET_X       = 3'd5,
        REG_OFFSET_Y       = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0] grid_size;
        logic [GRID_W-1:0] columns;
    } grid_cfg_t;

    typedef struct packed {
        logic [DIVW-1:0]   row;
        logic [GRID_W-1:0] col;
        logic [BLUE_W-1:0] blue;
    } cell_t;

    typedef struct packed {
        logic [DIVW-1:0]   num;
        logic [SIZE_W-1:0] rem;
    } div_state_t;

    function automatic div_state_t div_step(input div_state_t s, input logic [SIZE_W-1:0] d);
        div_state_t      r;
        logic [SIZE_W:0] t;
        r = s;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            t     = {r.rem, r.num[DIVW-1]};
            r.num = {r.num[DIVW-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t        = t - {1'b0, d};
                r.num[0] = 1'b1;
            end
            r.rem = t[SIZE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [BLUE_W-1:0] blue_of(input logic [BELIEF_W-1:0] b);
        logic [BLUE_PW-1:0] p;
        p = BLUE_PW'(b) * BLUE_PW'(BLUE_GAIN) + BLUE_PW'(BLUE_ROUND);
        return p[BELIEF_W+BLUE_W-1:BELIEF_W];
    endfunction

    function automatic logic [U_W-1:0] clamp_u(input logic [U_RAW_W-1:0] u);
        logic [U_W-1:0] c;
        if (64'(u) > 64'(U_MAX))
            c = U_MAX;
        else
            c = U_W'(u);
        return c;
    endfunction

    function automatic logic signed [PIX_W-1:0] to_pixel(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0]   q;
        logic signed [PIX_W-1:0] p;
        q = $signed(v[SUM_W-1:FRAC_BITS]);
        if (v[SUM_W-1] && (v[FRAC_BITS-1:0] != '0))
            q = q + Q_W'(1);
        if (q > Q_W'(PIX_MAX))
            p = PIX_W'(PIX_MAX);
        else if (q < Q_W'(PIX_MIN))
            p = PIX_W'(PIX_MIN);
        else
            p = q[PIX_W-1:0];
        return p;
    endfunction

endpackage

@@ sv/voxel_to_image_box.sv @@
// ----------------------------------------------------------------------------
// voxel_to_image_box
// Maps one belief grid voxel to a box in image pixels plus a blue level.
// Voxel channel: voxel_valid / voxel_stall with voxel_index, belief_level.
// Box channel: box_valid / box_stall with left, top, right, bottom, blue_level.
// Config channel: cfg_valid / cfg_ready with cfg_index, cfg_data; cfg_ready is
// always high, write only while no item is in flight.
// An item with zero belief is accepted and gives no box.
// Pipeline: an accepted voxel passes 13 stages of
// the index divider (modulo grid size, then row/column split, 4 bits a stage)
// and 5 mapping stages (multiply by interval, clamp, scale, offset, saturate).
// Throughput: one voxel per cycle; stages advance independently, so bubbles
// close up while box_stall is high and voxel_stall rises only once every
// stage holds an item. A stalled box holds its value.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module voxel_to_image_box
    import vtib_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       voxel_valid,
    output logic                       voxel_stall,
    input  logic [VOXEL_W-1:0]         voxel_index,
    input  logic [BELIEF_W-1:0]        belief_level,
    output logic                       box_valid,
    input  logic                       box_stall,
    output logic signed [PIX_W-1:0]    left,
    output logic signed [PIX_W-1:0]    top,
    output logic signed [PIX_W-1:0]    right,
    output logic signed [PIX_W-1:0]    bottom,
    output logic [BLUE_W-1:0]          blue_level,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int LANE_LEFT   = 0;
    localparam int LANE_TOP    = 1;
    localparam int LANE_RIGHT  = 2;
    localparam int LANE_BOTTOM = 3;

    logic [GRID_W-1:0]          cols_reg;
    logic [GRID_W-1:0]          rows_reg;
    logic [PI_W-1:0]            pi_reg;
    logic [SCALE_W-1:0]         scale_x_reg;
    logic [SCALE_W-1:0]         scale_y_reg;
    logic signed [OFFSET_W-1:0] offset_x_reg;
    logic signed [OFFSET_W-1:0] offset_y_reg;
    logic [SIZE_W-1:0]          grid_size_reg;
    logic [GRID_W-1:0]          cols_eff;
    logic [GRID_W-1:0]          rows_eff;
    grid_cfg_t                  grid_cfg;

    logic                       cell_valid;
    logic                       split_stall;
    cell_t                      grid_pos;

    logic [MAP_DEPTH-1:0]       map_valid_reg;
    logic [MAP_DEPTH:0]         map_ready;
    logic [BLUE_W-1:0]          blue_reg [MAP_DEPTH];

    logic [U_RAW_W-1:0]         px_reg;
    logic [U_RAW_W-1:0]         py_reg;
    logic [U_RAW_W-1:0]         px_next;
    logic [U_RAW_W-1:0]         py_next;
    logic [U_W-1:0]             u_reg    [NUM_LANES];
    logic [U_W-1:0]             u_next   [NUM_LANES];
    logic [PROD_W-1:0]          prod_reg  [NUM_LANES];
    logic [PROD_W-1:0]          prod_next [NUM_LANES];
    logic signed [SUM_W-1:0]    sum_reg  [NUM_LANES];
    logic signed [SUM_W-1:0]    sum_next [NUM_LANES];
    logic signed [PIX_W-1:0]    pix_reg  [NUM_LANES];
    logic signed [PIX_W-1:0]    pix_next [NUM_LANES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= GRID_W'(1);
            rows_reg     <= GRID_W'(1);
            pi_reg       <= PI_W'(1);
            scale_x_reg  <= SCALE_ONE;
            scale_y_reg  <= SCALE_ONE;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRID_COLUMNS:   cols_reg     <= cfg_data[GRID_W-1:0];
                REG_GRID_ROWS:      rows_reg     <= cfg_data[GRID_W-1:0];
                REG_PIXEL_INTERVAL: pi_reg       <= cfg_data[PI_W-1:0];
                REG_SCALE_X:        scale_x_reg  <= cfg_data[SCALE_W-1:0];
                REG_SCALE_Y:        scale_y_reg  <= cfg_data[SCALE_W-1:0];
                REG_OFFSET_X:       offset_x_reg <= $signed(cfg_data[OFFSET_W-1:0]);
                REG_OFFSET_Y:       offset_y_reg <= $signed(cfg_data[OFFSET_W-1:0]);
                default:            ;
            endcase
        end
    end

    assign cols_eff = (cols_reg == '0) ? GRID_W'(1) : cols_reg;
    assign rows_eff = (rows_reg == '0) ? GRID_W'(1) : rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grid_size_reg <= SIZE_W'(1);
        else
            grid_size_reg <= SIZE_W'(cols_eff) * SIZE_W'(rows_eff);
    end

    assign grid_cfg.grid_size = grid_size_reg;
    assign grid_cfg.columns   = cols_eff;

    vtib_grid_split u_split (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (voxel_valid),
        .item_stall   (voxel_stall),
        .voxel_index  (voxel_index),
        .belief_level (belief_level),
        .cfg          (grid_cfg),
        .cell_valid   (cell_valid),
        .cell_stall   (split_stall),
        .grid_pos     (grid_pos)
    );

    assign map_ready[MAP_DEPTH] = !box_stall;
    assign split_stall          = !map_ready[0];

    genvar m;
    generate
        for (m = 0; m < MAP_DEPTH; m++)
        begin : g_ready
            assign map_ready[m] = !map_valid_reg[m] || map_ready[m+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            map_valid_reg <= '0;
        else
        begin
            if (map_ready[0])
                map_valid_reg[0] <= cell_valid;
            for (int i = 1; i < MAP_DEPTH; i++)
            begin
                if (map_ready[i])
                    map_valid_reg[i] <= map_valid_reg[i-1];
            end
        end
    end

    always_comb
    begin
        px_next = U_RAW_W'(grid_pos.col) * U_RAW_W'(pi_reg);
        py_next = U_RAW_W'(grid_pos.row) * U_RAW_W'(pi_reg);

        u_next[LANE_LEFT]   = clamp_u(px_reg);
        u_next[LANE_TOP]    = clamp_u(py_reg);
        u_next[LANE_RIGHT]  = clamp_u(px_reg + U_RAW_W'(pi_reg));
        u_next[LANE_BOTTOM] = clamp_u(py_reg + U_RAW_W'(pi_reg));

        for (int l = 0; l < NUM_LANES; l++)
        begin
            prod_next[l] = PROD_W'(u_reg[l]) * PROD_W'(l[0] ? scale_y_reg : scale_x_reg);
            sum_next[l]  = $signed({2'b00, prod_reg[l]})
                         + SUM_W'(l[0] ? offset_y_reg : offset_x_reg);
            pix_next[l]  = to_pixel(sum_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_ready[0])
        begin
            px_reg      <= px_next;
            py_reg      <= py_next;
            blue_reg[0] <= grid_pos.blue;
        end
        for (int i = 1; i < MAP_DEPTH; i++)
        begin
            if (map_ready[i])
                blue_reg[i] <= blue_reg[i-1];
        end
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if (map_ready[1])
                u_reg[l] <= u_next[l];
            if (map_ready[2])
                prod_reg[l] <= prod_next[l];
            if (map_ready[3])
                sum_reg[l] <= sum_next[l];
            if (map_ready[4])
                pix_reg[l] <= pix_next[l];
        end
    end

    assign box_valid  = map_valid_reg[MAP_DEPTH-1];
    assign left       = pix_reg[LANE_LEFT];
    assign top        = pix_reg[LANE_TOP];
    assign right      = pix_reg[LANE_RIGHT];
    assign bottom     = pix_reg[LANE_BOTTOM];
    assign blue_level = blue_reg[MAP_DEPTH-1];

endmodule

@@ sv/vtib_grid_split.sv @@
// ----------------------------------------------------------------------------
// vtib_grid_split
// Pipelined restoring divider: reduces the voxel index modulo the grid size,
// then splits the remainder into grid row and column, four bits a stage.
// ----------------------------------------------------------------------------
module vtib_grid_split
    import vtib_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [VOXEL_W-1:0]  voxel_index,
    input  logic [BELIEF_W-1:0] belief_level,
    input  grid_cfg_t           cfg,
    output logic                cell_valid,
    input  logic                cell_stall,
    output cell_t               grid_pos
);

    logic [SPLIT_DEPTH-1:0] valid_reg;
    logic [SPLIT_DEPTH:0]   ready;
    div_state_t             state_reg [SPLIT_DEPTH];
    logic [BLUE_W-1:0]      blue_reg  [SPLIT_DEPTH];

    assign ready[SPLIT_DEPTH] = !cell_stall;
    assign item_stall         = !ready[0];

    genvar k;
    generate
        for (k = 0; k < SPLIT_DEPTH; k++)
        begin : g_stage
            div_state_t        state_next;
            logic [BLUE_W-1:0] blue_next;
            logic              valid_next;

            assign ready[k] = !valid_reg[k] || ready[k+1];

            if (k == 0)
            begin : g_entry
                always_comb
                begin
                    state_next.num = DIVW'(voxel_index[IDX_USE-1:0]);
                    state_next.rem = '0;
                    blue_next      = blue_of(belief_level);
                    valid_next     = item_valid && (belief_level != '0);
                end
            end
            else
            begin : g_div
                always_comb
                begin
                    div_state_t        src;
                    logic [SIZE_W-1:0] divisor;
                    src = state_reg[k-1];
                    if (k - 1 == DIV_STAGES)
                    begin
                        src.num = DIVW'(state_reg[k-1].rem);
                        src.rem = '0;
                    end
                    if (k <= DIV_STAGES)
                        divisor = cfg.grid_size;
                    else
                        divisor = SIZE_W'(cfg.columns);
                    state_next = div_step(src, divisor);
                    blue_next  = blue_reg[k-1];
                    valid_next = valid_reg[k-1];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (ready[k])
                    valid_reg[k] <= valid_next;
            end

            always_ff @(posedge clk)
            begin
                if (ready[k])
                begin
                    state_reg[k] <= state_next;
                    blue_reg[k]  <= blue_next;
                end
            end
        end
    endgenerate

    assign cell_valid    = valid_reg[SPLIT_DEPTH-1];
    assign grid_pos.row  = state_reg[SPLIT_DEPTH-1].num;
    assign grid_pos.col  = state_reg[SPLIT_DEPTH-1].rem[GRID_W-1:0];
    assign grid_pos.blue = blue_reg[SPLIT_DEPTH-1];

endmodule

@@ sv/voxel_to_image_box_checker.sv @@
// ----------------------------------------------------------------------------
// voxel_to_image_box_checker
// Port-level checks on the voxel to image box block, bound to the top level.
// ----------------------------------------------------------------------------
`include "voxel_to_image_box_macros.svh"

module voxel_to_image_box_checker
    import vtib_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    voxel_stall,
    input logic                    box_valid,
    input logic                    box_stall,
    input logic signed [PIX_W-1:0] left,
    input logic signed [PIX_W-1:0] top,
    input logic signed [PIX_W-1:0] right,
    input logic signed [PIX_W-1:0] bottom,
    input logic [BLUE_W-1:0]       blue_level
);

    logic                         box_held;
    logic [4*PIX_W+BLUE_W-1:0]    box_word;

    assign box_held = box_valid && box_stall;
    assign box_word = {left, top, right, bottom, blue_level};

    // a free output frees every stage back to the input
    `VTIB_ASSERT_NOW(a_open_when_drained, !box_stall, !voxel_stall, "voxel stalled with box free")

    // the map is monotone, so the far corner never lies before the near one
    `VTIB_ASSERT_NOW(a_box_x_ordered, box_valid, right >= left, "box right before left")
    `VTIB_ASSERT_NOW(a_box_y_ordered, box_valid, bottom >= top, "box bottom above top")

    `VTIB_ASSERT_NEXT(a_box_held, box_held, box_valid && $stable(box_word), "stalled box changed")

endmodule

bind voxel_to_image_box voxel_to_image_box_checker u_checker (.*);

@@ tb/tb_voxel_to_image_box.sv @@
// ----------------------------------------------------------------------------
// tb_voxel_to_image_box
// Drives voxels into the box mapper and checks every box against a predictor
// that splits the index into grid column and row, maps both cell corners
// through the per-axis scale and offset, and rounds the belief to a blue
// level. Directed items cover the field extremes, the register extremes, zero
// grid sizes, a zero cell side, zero belief and an unused register index.
// Random phases follow, each with its own register set, with random gaps on
// the voxel side and random stalls on the box side, but for one phase with neither.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_voxel_to_image_box;
    import vtib_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 30;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int IDLE_PCT        = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [PIX_W-1:0] left;
        logic signed [PIX_W-1:0] top;
        logic signed [PIX_W-1:0] right;
        logic signed [PIX_W-1:0] bottom;
        logic [BLUE_W-1:0]       blue;
    } box_t;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    voxel_valid  = 1'b0;
    logic                    voxel_stall;
    logic [VOXEL_W-1:0]      voxel_index  = '0;
    logic [BELIEF_W-1:0]     belief_level = '0;
    logic                    box_valid;
    logic                    box_stall    = 1'b0;
    logic signed [PIX_W-1:0] left;
    logic signed [PIX_W-1:0] top;
    logic signed [PIX_W-1:0] right;
    logic signed [PIX_W-1:0] bottom;
    logic [BLUE_W-1:0]       blue_level;
    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0]   cfg_data     = '0;

    logic [GRID_W-1:0]          grid_cols_q = GRID_W'(1);
    logic [GRID_W-1:0]          grid_rows_q = GRID_W'(1);
    logic [PI_W-1:0]            cell_side   = PI_W'(1);
    logic [SCALE_W-1:0]         gain_x      = SCALE_ONE;
    logic [SCALE_W-1:0]         gain_y      = SCALE_ONE;
    logic signed [OFFSET_W-1:0] offs_x      = '0;
    logic signed [OFFSET_W-1:0] offs_y      = '0;

    int   voxel_idle_pct = IDLE_PCT;
    int   box_idle_pct   = IDLE_PCT;
    int   mismatches     = 0;
    int   quiet_cycles   = 0;
    box_t box_expect[$];

    voxel_to_image_box i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .voxel_valid  (voxel_valid),
        .voxel_stall  (voxel_stall),
        .voxel_index  (voxel_index),
        .belief_level (belief_level),
        .box_valid    (box_valid),
        .box_stall    (box_stall),
        .left         (left),
        .top          (top),
        .right        (right),
        .bottom       (bottom),
        .blue_level   (blue_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic signed [PIX_W-1:0] map_to_image(
        input longint unsigned           u,
        input logic [SCALE_W-1:0]        gain,
        input logic signed [OFFSET_W-1:0] offs
    );
        longint unsigned prod;
        longint          sum;
        longint          whole;
        prod  = u * gain;
        sum   = longint'(prod) + longint'(offs);
        whole = sum / (longint'(1) << FRAC_BITS);
        if (whole > PIX_MAX)
            return PIX_W'(PIX_MAX);
        if (whole < PIX_MIN)
            return PIX_W'(PIX_MIN);
        return whole[PIX_W-1:0];
    endfunction

    function automatic box_t predict_box(
        input logic [VOXEL_W-1:0]  idx,
        input logic [BELIEF_W-1:0] belief
    );
        longint unsigned cols;
        longint unsigned rows;
        longint unsigned slot;
        longint unsigned px;
        longint unsigned py;
        longint unsigned side;
        int unsigned     blue_raw;
        box_t            b;
        cols     = (grid_cols_q == '0) ? 64'd1 : 64'(grid_cols_q);
        rows     = (grid_rows_q == '0) ? 64'd1 : 64'(grid_rows_q);
        slot     = 64'(idx[IDX_USE-1:0]) % (cols * rows);
        side     = 64'(cell_side);
        px       = (slot % cols) * side;
        py       = (slot / cols) * side;
        b.left   = map_to_image(px, gain_x, offs_x);
        b.top    = map_to_image(py, gain_y, offs_y);
        b.right  = map_to_image(px + side, gain_x, offs_x);
        b.bottom = map_to_image(py + side, gain_y, offs_y);
        blue_raw = belief;
        blue_raw = blue_raw * 255 + 32768;
        b.blue   = BLUE_W'(blue_raw >> 16);
        return b;
    endfunction

    function automatic logic [GRID_W-1:0] pick_grid();
        case ($urandom_range(9))
            0:       return GRID_W'($urandom_range(0, 8191));
            1:       return GRID_W'(4096);
            default: return GRID_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        if ($urandom_range(7) == 0)
            return SCALE_W'($urandom);
        return SCALE_W'($urandom_range(16384, 196608));
    endfunction

    function automatic logic signed [OFFSET_W-1:0] pick_offset();
        if ($urandom_range(7) == 0)
            return OFFSET_W'($urandom);
        return OFFSET_W'($urandom_range(0, 400 << 16) - (200 << 16));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic record_write(
        input logic [CFG_INDEX_W-1:0] idx,
        input logic [CFG_DATA_W-1:0]  data
    );
        case (idx)
            REG_GRID_COLUMNS:   grid_cols_q = data[GRID_W-1:0];
            REG_GRID_ROWS:      grid_rows_q = data[GRID_W-1:0];
            REG_PIXEL_INTERVAL: cell_side   = data[PI_W-1:0];
            REG_SCALE_X:        gain_x      = data[SCALE_W-1:0];
            REG_SCALE_Y:        gain_y      = data[SCALE_W-1:0];
            REG_OFFSET_X:       offs_x      = data;
            REG_OFFSET_Y:       offs_y      = data;
            default:            ;
        endcase
    endtask

    task automatic send_voxel(input logic [VOXEL_W-1:0] idx, input logic [BELIEF_W-1:0] belief);
        while ($urandom_range(99) < voxel_idle_pct)
        begin
            voxel_valid <= 1'b0;
            @(posedge clk);
        end
        voxel_valid  <= 1'b1;
        voxel_index  <= idx;
        belief_level <= belief;
        @(posedge clk);
        while (voxel_stall)
            @(posedge clk);
        if (belief != '0)
            box_expect.push_back(predict_box(idx, belief));
    endtask

    task automatic wait_drained();
        voxel_valid <= 1'b0;
        while (box_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        record_write(idx, data);
    endtask

    // fill unused upper data bits with noise; the block must drop them
    task automatic load_config(
        input logic [GRID_W-1:0]          cols,
        input logic [GRID_W-1:0]          rows,
        input logic [PI_W-1:0]            side,
        input logic [SCALE_W-1:0]         sx,
        input logic [SCALE_W-1:0]         sy,
        input logic signed [OFFSET_W-1:0] ox,
        input logic signed [OFFSET_W-1:0] oy
    );
        logic [CFG_DATA_W-1:0] junk;
        wait_drained();
        junk = $urandom;
        write_reg(REG_GRID_COLUMNS, {junk[CFG_DATA_W-1:GRID_W], cols});
        junk = $urandom;
        write_reg(REG_GRID_ROWS, {junk[CFG_DATA_W-1:GRID_W], rows});
        junk = $urandom;
        write_reg(REG_PIXEL_INTERVAL, {junk[CFG_DATA_W-1:PI_W], side});
        junk = $urandom;
        write_reg(REG_SCALE_X, {junk[CFG_DATA_W-1:SCALE_W], sx});
        junk = $urandom;
        write_reg(REG_SCALE_Y, {junk[CFG_DATA_W-1:SCALE_W], sy});
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_voxel(24'h000000, 16'hFFFF);
        send_voxel(24'hFFFFFF, 16'h0001);
        send_voxel(24'h800000, 16'h0000);
        send_voxel(24'h123456, 16'h0080);
        send_voxel(24'h000001, 16'h0081);
        send_voxel(24'hABCDEF, 16'h8000);
    endtask

    task automatic test_config_extremes();
        load_config(GRID_W'(4096), GRID_W'(4096), PI_W'(1024), '1, '1,
                    32'sh7FFF_FFFF, 32'sh8000_0000);
        send_voxel(24'h000000, 16'hFFFF);
        send_voxel(24'hFFFFFF, 16'h7FFF);
        send_voxel(24'h000FFF, 16'h0100);
        send_voxel(24'hFFF000, 16'h0000);
        // grid above range, zero scale
        load_config(GRID_W'(8191), GRID_W'(8191), PI_W'(1024), '0, '0,
                    32'sh8000_0000, 32'sh7FFF_FFFF);
        send_voxel(24'hFFFFFF, 16'h4000);
        send_voxel(24'h001FFE, 16'hC000);
        // zero grid and zero cell side
        load_config('0, '0, '0, SCALE_ONE, SCALE_ONE, '0, '0);
        send_voxel(24'h5A5A5A, 16'h2222);
        send_voxel(24'hA5A5A5, 16'hDDDD);
        // fractional results on both sides of zero truncate toward zero
        load_config(GRID_W'(16), GRID_W'(16), PI_W'(8), SCALE_W'(24'h018000),
                    SCALE_W'(24'h00C000), -32'sh0005_8000, 32'sh0003_0001);
        send_voxel(24'h000000, 16'h1234);
        send_voxel(24'h000011, 16'h0F0F);
        send_voxel(24'h0000FF, 16'hF0F0);
    endtask

    task automatic test_unknown_register();
        wait_drained();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_voxel(24'h0000FF, 16'h0001);
        send_voxel(24'h000035, 16'hFFFE);
    endtask

    task automatic test_random_traffic();
        logic [BELIEF_W-1:0] belief;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            load_config(pick_grid(), pick_grid(),
                        ($urandom_range(4) == 0) ? PI_W'($urandom_range(0, 2047))
                                                 : PI_W'($urandom_range(1, 32)),
                        pick_scale(), pick_scale(), pick_offset(), pick_offset());
            voxel_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
            box_idle_pct   = (phase == 3) ? 0 : IDLE_PCT;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                case ($urandom_range(9))
                    0:       belief = '0;
                    1:       belief = $urandom_range(1) ? 16'hFFFF : 16'h0001;
                    default: belief = BELIEF_W'($urandom);
                endcase
                send_voxel(VOXEL_W'($urandom), belief);
                // hold the sender until every box has come out
                if (phase == 5 && i == ITEMS_PER_PHASE / 2)
                    wait_drained();
            end
        end
        voxel_idle_pct = IDLE_PCT;
        box_idle_pct   = IDLE_PCT;
    endtask

    always @(posedge clk)
        box_stall <= ($urandom_range(99) < box_idle_pct);

    always @(posedge clk)
    begin
        box_t want;
        if (rst_n && box_valid && !box_stall)
        begin
            if (box_expect.size() == 0)
                report_mismatch("box with no voxel pending", 1, 0);
            else
            begin
                want = box_expect.pop_front();
                if (left !== want.left)
                    report_mismatch("left", int'(left), int'(want.left));
                if (top !== want.top)
                    report_mismatch("top", int'(top), int'(want.top));
                if (right !== want.right)
                    report_mismatch("right", int'(right), int'(want.right));
                if (bottom !== want.bottom)
                    report_mismatch("bottom", int'(bottom), int'(want.bottom));
                if (blue_level !== want.blue)
                    report_mismatch("blue_level", int'(blue_level), int'(want.blue));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((voxel_valid && !voxel_stall) || (box_valid && !box_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_config_extremes();
        test_unknown_register();
        test_random_traffic();
        wait_drained();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
